// ===== hdl/sea_pkg.sv =====
// shared types, sizes and helpers for the sparse entry accumulator
`timescale 1ns / 1ps
package sea_pkg;

  localparam int CAPACITY   = 256;
  localparam int INDEX_BITS = 16;
  localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 2 * INDEX_BITS;
  localparam int VALUE_W    = 32;

  typedef logic [INDEX_BITS-1:0]     idx_t;
  typedef logic [KEY_W-1:0]          key_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_SUMMED  = 3'd1,
    ST_SKIPPED = 3'd2,
    ST_FULL    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } ctrl_state_t;

  // request handed from the front end to the scan sequencer
  typedef struct packed {
    logic   is_read;
    logic   skip;
    key_t   key;
    value_t value;
  } req_t;

  // result handed back when a request completes
  typedef struct packed {
    status_t status;
    value_t  value;
    count_t  count;
  } res_t;

  function automatic value_t sat_add(value_t a, value_t b);
    logic signed [VALUE_W:0] s;
    value_t r;
    s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      r = s[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sea_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sea_ctrl.sv =====
// scan sequencer: walks the key table, sums or appends, keeps the entry count
`timescale 1ns / 1ps
module sea_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  sea_pkg::req_t  req,
  output logic           ready,
  input  logic           out_free,
  output logic           done,
  output sea_pkg::res_t  res
);
  import sea_pkg::*;

  ctrl_state_t state_r, state_nxt;
  req_t        req_r;
  count_t      issue_r, issue_nxt;
  count_t      count_r, count_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;
  slot_t       cmp_slot_r;
  logic        hit_r, hit_nxt;
  slot_t       slot_r, slot_nxt;
  value_t      hit_val_r, hit_val_nxt;

  logic   key_we, val_we;
  slot_t  key_waddr, val_waddr;
  value_t val_wdata;
  key_t   key_rdata;
  value_t val_rdata;
  slot_t  rd_slot;

  assign rd_slot = issue_r[SLOT_W-1:0];

  sea_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (req_r.key),
    .raddr (rd_slot),
    .rdata (key_rdata)
  );

  sea_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_slot),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && ready) begin
      req_r <= req;
    end
    issue_r    <= issue_nxt;
    cmp_slot_r <= rd_slot;
    slot_r     <= slot_nxt;
    hit_val_r  <= hit_val_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    issue_nxt   = issue_r;
    count_nxt   = count_r;
    cmp_vld_nxt = 1'b0;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    hit_val_nxt = hit_val_r;
    ready       = 1'b0;
    done        = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    key_waddr   = count_r[SLOT_W-1:0];
    val_waddr   = count_r[SLOT_W-1:0];
    val_wdata   = req_r.value;
    res.status  = ST_MISS;
    res.value   = '0;
    res.count   = count_r;

    case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          issue_nxt = '0;
          hit_nxt   = 1'b0;
          state_nxt = req.skip ? S_UPDATE : S_SCAN;
        end
      end

      S_SCAN: begin
        // read data comes from the ram's read register, in the cycle after its address is issued
        if (cmp_vld_r && (key_rdata == req_r.key)) begin
          hit_nxt     = 1'b1;
          slot_nxt    = cmp_slot_r;
          hit_val_nxt = val_rdata;
          state_nxt   = S_UPDATE;
        end else if ((issue_r == count_r) && !cmp_vld_r) begin
          state_nxt = S_UPDATE;
        end else if (issue_r != count_r) begin
          cmp_vld_nxt = 1'b1;
          issue_nxt   = issue_r + 1'b1;
        end
      end

      S_UPDATE: begin
        if (req_r.skip) begin
          res.status = ST_SKIPPED;
        end else if (req_r.is_read) begin
          res.status = hit_r ? ST_HIT : ST_MISS;
          res.value  = hit_r ? hit_val_r : '0;
        end else if (hit_r) begin
          res.status = ST_SUMMED;
          val_waddr  = slot_r;
          val_wdata  = sat_add(hit_val_r, req_r.value);
          val_we     = out_free;
        end else if (count_r == COUNT_W'(CAPACITY)) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_NEW;
          res.count  = count_r + 1'b1;
          key_we     = out_free;
          val_we     = out_free;
        end
        if (out_free) begin
          done      = 1'b1;
          count_nxt = res.count;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sparse_entry_accumulator_unit.sv =====
// sparse entry accumulator top level: config, high marks, result register
//
// Input channel (in_valid/in_ready) takes one request word: add (req_type 0)
// or read (req_type 1) of the entry keyed by row and column. The result
// channel (out_valid/out_ready) returns one word per request: status, read
// value, entry count and the largest row and column seen by adds.
// Each request that is not skipped walks the stored key table one entry per
// cycle through a single key ram read port and one comparator; a hit ends
// the walk early, and a skipped lower-triangle add does not walk the table.
// One request is in flight at a time: in_ready is low meanwhile, and the
// next request is taken in the cycle after the result is written.
// The result register lets the next request be accepted while a word still
// waits at the output; if the receiver keeps stalling, the following
// request finishes its walk and then holds until the register frees up.
// Users write symmetric mode (cfg_wr_en) only while the block idles; the block does not enforce it.
// Synchronous reset empties the table (count zero), clears both high marks
// and symmetric mode, and drops any pending result; no clearing pass runs.
`timescale 1ns / 1ps
module sparse_entry_accumulator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [15:0]        in_row_idx,
  input  logic [15:0]        in_col_idx,
  input  logic signed [31:0] in_add_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_entry_count,
  output logic [15:0]        out_largest_row,
  output logic [15:0]        out_largest_col,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import sea_pkg::*;

  logic    sym_mode_r;
  idx_t    row_mark_r;
  idx_t    col_mark_r;
  idx_t    row_in, col_in;
  logic    accept;
  logic    out_free;
  logic    res_done;
  req_t    req;
  res_t    res;

  logic    out_valid_r;
  status_t out_status_r;
  value_t  out_value_r;
  count_t  out_count_r;
  idx_t    out_row_r;
  idx_t    out_col_r;

  assign row_in   = idx_t'(in_row_idx);
  assign col_in   = idx_t'(in_col_idx);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign req.is_read = in_req_type;
  assign req.skip    = !in_req_type && sym_mode_r && (row_in > col_in);
  assign req.key     = {row_in, col_in};
  assign req.value   = in_add_value;

  sea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid),
    .req      (req),
    .ready    (in_ready),
    .out_free (out_free),
    .done     (res_done),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_mode_r  <= 1'b0;
      row_mark_r  <= '0;
      col_mark_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sym_mode_r <= cfg_wr_data;
      end
      // high marks move on every add, stored or not
      if (accept && !in_req_type) begin
        if (row_in > row_mark_r) begin
          row_mark_r <= row_in;
        end
        if (col_in > col_mark_r) begin
          col_mark_r <= col_in;
        end
      end
      if (res_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
      out_count_r  <= res.count;
      out_row_r    <= row_mark_r;
      out_col_r    <= col_mark_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_entry_count = 9'(out_count_r);
  assign out_largest_row = 16'(out_row_r);
  assign out_largest_col = 16'(out_col_r);

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) accept |=> !in_ready
  ) else $error("request accepted while a walk was already running");

  a_done_into_free_slot: assert property (
    @(posedge clk) disable iff (!rst_n) res_done |-> out_free
  ) else $error("result finished while the output register was still full");

  a_zero_unless_hit: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && (out_status_r != ST_HIT)) |-> (out_value_r == '0)
  ) else $error("nonzero read value on a result that is not a read hit");
`endif

endmodule
